// ===== hdl/jcsl_pkg.sv =====
`timescale 1ns / 1ps

package jcsl_pkg;

	localparam int AXES           = 16;
	localparam int AXIS_BITS      = 4;
	localparam int AXIS_IDX_BITS  = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int VALUE_BITS     = 32;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [AXIS_BITS-1:0]         axis_t;
	typedef logic [AXIS_IDX_BITS-1:0]     axis_idx_t;

	localparam value_t VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam value_t VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		KIND_SEED   = 2'd0,
		KIND_LIMITS = 2'd1,
		KIND_ACTION = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OUTCOME_OK    = 2'd0,
		OUTCOME_BAD   = 2'd1,
		OUTCOME_LIMIT = 2'd2,
		OUTCOME_RSVD  = 2'd3
	} outcome_t;

	// enable bits of one axis
	localparam int EN_FLOOR = 0;
	localparam int EN_CEIL  = 1;
	localparam int EN_STEP  = 2;

	typedef struct packed {
		value_t     floor_limit;
		value_t     ceiling_limit;
		value_t     step_limit;
		logic [2:0] en;
	} limits_t;

	typedef struct packed {
		kind_t   kind;
		axis_t   axis;
		value_t  sample;
		logic    sample_bad;
		limits_t limits;
	} item_t;

	typedef struct packed {
		value_t   filtered;
		outcome_t outcome;
		axis_t    axis;
	} result_t;

	typedef struct packed {
		logic      last_we;
		logic      limits_we;
		axis_idx_t idx;
		value_t    last;
		limits_t   limits;
	} tbl_wr_t;

	function automatic value_t clamp(input value_t v, input value_t lo, input value_t hi);
		value_t r;
		r = v;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	// add or subtract with saturation at the signed value range
	function automatic value_t sat_add(input value_t a, input value_t b, input logic sub);
		logic signed [VALUE_BITS:0] s;
		s = sub ? ($signed({a[VALUE_BITS-1], a}) - $signed({b[VALUE_BITS-1], b}))
		        : ($signed({a[VALUE_BITS-1], a}) + $signed({b[VALUE_BITS-1], b}));
		if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
			return s[VALUE_BITS] ? VMIN : VMAX;
		end
		return s[VALUE_BITS-1:0];
	endfunction

endpackage

// ===== hdl/joint_clamp_slew_limiter_unit.sv =====
`timescale 1ns / 1ps

// Per-axis clamp and slew limiter for Q16.16 position commands.
// Input channel (in_valid/in_ready) takes one item per transaction: kind 0
// seeds an axis's last position, kind 1 loads its floor, ceiling and step
// limits with enables, kind 2 filters an action sample. Every item gives
// exactly one result on the output channel (out_valid/out_ready): filtered
// value, outcome code and axis.
// Pipeline: the item is held in the input register, then the
// per-axis table read, clamp, step limit and table write happen in one pass
// into the result register.
// Throughput is one item per cycle while the receiver takes every result; a
// write to the last-position table is seen by the next item on the following cycle.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; in_ready drops only when both are full.
// cfg_valid/cfg_ready writes reject_bad_values from cfg_data; write it only
// while the block is idle.
// Reset clears all axis tables to zero (every limit off) and sets
// reject_bad_values to 1.
module joint_clamp_slew_limiter_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            kind,
	input  logic [3:0]            axis,
	input  logic signed [31:0]    sample,
	input  logic                  sample_bad,
	input  logic signed [31:0]    floor_limit,
	input  logic signed [31:0]    ceiling_limit,
	input  logic signed [31:0]    step_limit,
	input  logic                  floor_on,
	input  logic                  ceiling_on,
	input  logic                  step_on,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [31:0]    filtered,
	output logic [1:0]            outcome,
	output logic [3:0]            axis_out
);
	import jcsl_pkg::*;

	logic      reject_bad_values_q;
	logic      valid_s1;
	item_t     item_s1;
	logic      out_valid_q;
	result_t   res_q;
	logic      advance;
	axis_idx_t rd_idx;
	value_t    rd_last;
	limits_t   rd_limits;
	result_t   res;
	tbl_wr_t   wr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_bad_values_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			reject_bad_values_q <= cfg_data;
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind                 <= kind_t'(kind);
			item_s1.axis                 <= axis;
			item_s1.sample               <= sample;
			item_s1.sample_bad           <= sample_bad;
			item_s1.limits.floor_limit   <= floor_limit;
			item_s1.limits.ceiling_limit <= ceiling_limit;
			item_s1.limits.step_limit    <= step_limit;
			item_s1.limits.en            <= {step_on, ceiling_on, floor_on};
		end
	end

	jcsl_axis_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_idx    (rd_idx),
		.rd_last   (rd_last),
		.rd_limits (rd_limits),
		.wr        (wr)
	);

	jcsl_limit_core u_core (
		.fire       (advance),
		.reject_bad (reject_bad_values_q),
		.item       (item_s1),
		.prev       (rd_last),
		.lim        (rd_limits),
		.rd_idx     (rd_idx),
		.res        (res),
		.wr         (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = res_q.filtered;
	assign outcome   = res_q.outcome;
	assign axis_out  = res_q.axis;

`ifndef NO_ASSERTIONS
	// an error result never carries a value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome != OUTCOME_OK) |-> filtered == '0)
		else $error("error result with nonzero value");

	// an empty result register always lets the input side move
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");

	// a staged item reaches a free result register in the following cycle
	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("staged transaction not delivered");

	// the tables change only when an item leaves the input register
	a_write_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.last_we || wr.limits_we) |-> advance)
		else $error("table write without transaction");
`endif

endmodule

// ===== hdl/jcsl_axis_table.sv =====
`timescale 1ns / 1ps

module jcsl_axis_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jcsl_pkg::axis_idx_t  rd_idx,
	output jcsl_pkg::value_t     rd_last,
	output jcsl_pkg::limits_t    rd_limits,
	input  jcsl_pkg::tbl_wr_t    wr
);
	import jcsl_pkg::*;

	value_t  last_q   [AXES];
	limits_t limits_q [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				last_q[i]   <= '0;
				limits_q[i] <= '0;
			end
		end else begin
			if (wr.last_we) begin
				last_q[wr.idx] <= wr.last;
			end
			if (wr.limits_we) begin
				limits_q[wr.idx] <= wr.limits;
			end
		end
	end

	assign rd_last   = last_q[rd_idx];
	assign rd_limits = limits_q[rd_idx];

endmodule

// ===== hdl/jcsl_limit_core.sv =====
`timescale 1ns / 1ps

module jcsl_limit_core (
	input  logic               fire,
	input  logic               reject_bad,
	input  jcsl_pkg::item_t    item,
	input  jcsl_pkg::value_t   prev,
	input  jcsl_pkg::limits_t  lim,
	output jcsl_pkg::axis_idx_t rd_idx,
	output jcsl_pkg::result_t  res,
	output jcsl_pkg::tbl_wr_t  wr
);
	import jcsl_pkg::*;

	logic   in_range;
	logic   limits_bad;
	value_t lo, hi, up, dn, v_in, v_bound, v_step, v_final;

	assign in_range = 32'(item.axis) < AXES;
	assign rd_idx   = item.axis[AXIS_IDX_BITS-1:0];

	assign lo = lim.en[EN_FLOOR] ? lim.floor_limit : VMIN;
	assign hi = lim.en[EN_CEIL] ? lim.ceiling_limit : VMAX;
	assign limits_bad = (lo > hi) || (lim.en[EN_STEP] && lim.step_limit < 0);

	// a held sample reuses the last position
	assign v_in    = item.sample_bad ? prev : item.sample;
	assign v_bound = clamp(v_in, lo, hi);
	assign up      = sat_add(prev, lim.step_limit, 1'b0);
	assign dn      = sat_add(prev, lim.step_limit, 1'b1);
	assign v_step  = lim.en[EN_STEP] ? clamp(v_bound, dn, up) : v_bound;
	assign v_final = clamp(v_step, lo, hi);

	always_comb begin
		res.filtered  = '0;
		res.outcome   = OUTCOME_OK;
		res.axis      = item.axis;
		wr.last_we    = 1'b0;
		wr.limits_we  = 1'b0;
		wr.idx        = rd_idx;
		wr.last       = item.sample;
		wr.limits     = item.limits;
		if (in_range) begin
			unique case (item.kind)
				KIND_SEED: begin
					wr.last_we = fire;
				end
				KIND_LIMITS: begin
					wr.limits_we = fire;
				end
				KIND_ACTION: begin
					if (item.sample_bad && reject_bad) begin
						res.outcome = OUTCOME_BAD;
					end else if (limits_bad) begin
						res.outcome = OUTCOME_LIMIT;
					end else begin
						res.filtered = v_final;
						wr.last      = v_final;
						wr.last_we   = fire;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== dv/joint_clamp_slew_limiter_unit_tb.sv =====
`timescale 1ns / 1ps

module joint_clamp_slew_limiter_unit_tb;
	import jcsl_pkg::*;

	localparam int          PIPE_LAT    = 2;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam value_t      ONE         = 32'sh0001_0000;

	localparam logic [2:0] USE_NONE  = 3'b000;
	localparam logic [2:0] USE_FLOOR = 3'(1 << EN_FLOOR);
	localparam logic [2:0] USE_CEIL  = 3'(1 << EN_CEIL);
	localparam logic [2:0] USE_STEP  = 3'(1 << EN_STEP);
	localparam logic [2:0] USE_ALL   = USE_FLOOR | USE_CEIL | USE_STEP;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         kind;
	logic [3:0]         axis;
	logic signed [31:0] sample;
	logic               sample_bad;
	logic signed [31:0] floor_limit;
	logic signed [31:0] ceiling_limit;
	logic signed [31:0] step_limit;
	logic               floor_on;
	logic               ceiling_on;
	logic               step_on;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] filtered;
	logic [1:0]         outcome;
	logic [3:0]         axis_out;

	// predicted block state
	value_t     last_pos [AXES];
	value_t     floor_tbl [AXES];
	value_t     ceil_tbl [AXES];
	value_t     step_tbl [AXES];
	logic [2:0] en_tbl [AXES];
	bit         reject_bad;

	result_t     expected_q [$];
	int unsigned cycle_count;
	int unsigned fail_count;
	int unsigned checked_count;
	int unsigned kind_count [4];
	int unsigned outcome_count [4];
	bit          in_gaps_on = 1'b1;
	bit          out_stalls_on = 1'b1;

	joint_clamp_slew_limiter_unit u_dut (.*);

	initial begin
		clk = 1'b0;
		forever begin
			#4 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic value_t saturate(logic signed [VALUE_BITS:0] wide);
		if (wide > VMAX) begin
			return VMAX;
		end
		if (wide < VMIN) begin
			return VMIN;
		end
		return wide[VALUE_BITS-1:0];
	endfunction

	function automatic value_t bound_to(value_t v, value_t lo, value_t hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// update the predicted tables for one item and return its result
	function automatic result_t apply_item(item_t it);
		result_t    r;
		axis_idx_t  a;
		value_t     prev, v, lo, hi, up, dn;
		logic [2:0] en;
		r.filtered = '0;
		r.outcome = OUTCOME_OK;
		r.axis = it.axis;
		a = it.axis;
		case (it.kind)
			KIND_SEED: begin
				last_pos[a] = it.sample;
			end
			KIND_LIMITS: begin
				floor_tbl[a] = it.limits.floor_limit;
				ceil_tbl[a] = it.limits.ceiling_limit;
				step_tbl[a] = it.limits.step_limit;
				en_tbl[a] = it.limits.en;
			end
			KIND_ACTION: begin
				prev = last_pos[a];
				v = it.sample;
				en = en_tbl[a];
				lo = en[EN_FLOOR] ? floor_tbl[a] : VMIN;
				hi = en[EN_CEIL] ? ceil_tbl[a] : VMAX;
				if (it.sample_bad && reject_bad) begin
					r.outcome = OUTCOME_BAD;
				end else begin
					if (it.sample_bad) begin
						v = prev;
					end
					if (lo > hi || (en[EN_STEP] && step_tbl[a] < 0)) begin
						r.outcome = OUTCOME_LIMIT;
					end else begin
						v = bound_to(v, lo, hi);
						if (en[EN_STEP]) begin
							up = saturate((VALUE_BITS+1)'(prev) + (VALUE_BITS+1)'(step_tbl[a]));
							dn = saturate((VALUE_BITS+1)'(prev) - (VALUE_BITS+1)'(step_tbl[a]));
							v = bound_to(v, dn, up);
						end
						v = bound_to(v, lo, hi);
						last_pos[a] = v;
						r.filtered = v;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// mostly zero, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	function automatic item_t make_item(kind_t k, int unsigned ax, value_t s, logic bad,
			value_t fl, value_t cl, value_t st, logic [2:0] en);
		item_t it;
		it.kind = k;
		it.axis = AXIS_BITS'(ax);
		it.sample = s;
		it.sample_bad = bad;
		it.limits.floor_limit = fl;
		it.limits.ceiling_limit = cl;
		it.limits.step_limit = st;
		it.limits.en = en;
		return it;
	endfunction

	function automatic value_t rand_value();
		value_t v;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 4))
				0: v = VMAX;
				1: v = VMIN;
				2: v = 0;
				3: v = 1;
				default: v = -1;
			endcase
		end else if (pick < 5) begin
			v = $urandom_range(0, 20 * 65536);
			v = v - 10 * ONE;
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	function automatic value_t near_value(value_t prev);
		value_t d;
		d = $urandom_range(0, 2 * 65536);
		d = d - ONE;
		return saturate((VALUE_BITS+1)'(prev) + (VALUE_BITS+1)'(d));
	endfunction

	function automatic item_t random_item();
		item_t       it;
		int unsigned pick, ax;
		value_t      a, b, st;
		ax = $urandom_range(0, AXES - 1);
		it = make_item(KIND_NONE, ax, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom,
			$urandom, 3'($urandom_range(0, 7)));
		pick = $urandom_range(0, 99);
		if (pick < 14) begin
			it.kind = KIND_LIMITS;
			// most limit loads are consistent, the rest stay raw noise
			if ($urandom_range(0, 4) != 0) begin
				a = rand_value();
				b = rand_value();
				it.limits.floor_limit = (a < b) ? a : b;
				it.limits.ceiling_limit = (a < b) ? b : a;
				if ($urandom_range(0, 3) == 0) begin
					st = $urandom;
					st[VALUE_BITS-1] = 1'b0;
				end else begin
					st = $urandom_range(0, 2 * 65536);
				end
				it.limits.step_limit = st;
			end
		end else if (pick < 24) begin
			it.kind = KIND_SEED;
			it.sample = rand_value();
		end else if (pick < 96) begin
			it.kind = KIND_ACTION;
			it.sample = $urandom_range(0, 1) ? near_value(last_pos[axis_idx_t'(ax)])
				: rand_value();
			it.sample_bad = ($urandom_range(0, 9) == 0);
		end
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int unsigned gap;
		gap = in_gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		kind = it.kind;
		axis = it.axis;
		sample = it.sample;
		sample_bad = it.sample_bad;
		floor_limit = it.limits.floor_limit;
		ceiling_limit = it.limits.ceiling_limit;
		step_limit = it.limits.step_limit;
		floor_on = it.limits.en[EN_FLOOR];
		ceiling_on = it.limits.en[EN_CEIL];
		step_on = it.limits.en[EN_STEP];
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(apply_item(it));
		kind_count[it.kind]++;
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	task automatic set_reject_bad(input bit on);
		wait_for_drain();
		@(negedge clk);
		cfg_data = on;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		reject_bad = on;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned done;
		item_t       it;
		done = 0;
		while (done < count) begin
			it = random_item();
			send_item(it);
			if (it.kind != KIND_NONE) begin
				done++;
			end
		end
	endtask

	task automatic test_reset_defaults();
		send_item(make_item(KIND_ACTION, 0, VMAX, 1'b0, 0, 0, 0, USE_NONE));
		send_item(make_item(KIND_ACTION, 15, VMIN, 1'b0, 0, 0, 0, USE_NONE));
		send_item(make_item(KIND_NONE, 7, -1, 1'b1, VMAX, VMIN, -1, USE_ALL));
		// seed ignores the bad flag
		send_item(make_item(KIND_SEED, 3, 32'sh1234_5678, 1'b1, 0, 0, 0, USE_NONE));
		send_item(make_item(KIND_ACTION, 3, VMIN, 1'b1, 0, 0, 0, USE_NONE));
	endtask

	task automatic test_bad_sample_policy();
		set_reject_bad(1'b0);
		send_item(make_item(KIND_ACTION, 3, VMIN, 1'b1, 0, 0, 0, USE_NONE));
		send_item(make_item(KIND_LIMITS, 3, 0, 1'b0, -ONE, ONE, 0, USE_FLOOR | USE_CEIL));
		send_item(make_item(KIND_ACTION, 3, VMAX, 1'b1, 0, 0, 0, USE_NONE));
		set_reject_bad(1'b1);
		send_item(make_item(KIND_ACTION, 3, 0, 1'b1, 0, 0, 0, USE_NONE));
	endtask

	task automatic test_bounds_and_slew();
		send_item(make_item(KIND_LIMITS, 2, 0, 1'b0, -2 * ONE, 2 * ONE, ONE / 4, USE_ALL));
		send_item(make_item(KIND_SEED, 2, 0, 1'b0, 0, 0, 0, USE_NONE));
		send_item(make_item(KIND_ACTION, 2, 10 * ONE, 1'b0, 0, 0, 0, USE_NONE));
		send_item(make_item(KIND_ACTION, 2, -10 * ONE, 1'b0, 0, 0, 0, USE_NONE));
		send_item(make_item(KIND_ACTION, 2, ONE / 8, 1'b0, 0, 0, 0, USE_NONE));
		// floor above ceiling
		send_item(make_item(KIND_LIMITS, 2, 0, 1'b0, 3 * ONE, ONE, ONE, USE_ALL));
		send_item(make_item(KIND_ACTION, 2, ONE, 1'b0, 0, 0, 0, USE_NONE));
		// same bounds with the floor disabled are fine
		send_item(make_item(KIND_LIMITS, 2, 0, 1'b0, 3 * ONE, ONE, ONE, USE_CEIL));
		send_item(make_item(KIND_ACTION, 2, 5 * ONE, 1'b0, 0, 0, 0, USE_NONE));
		send_item(make_item(KIND_LIMITS, 2, 0, 1'b0, 0, 0, -1, USE_STEP));
		send_item(make_item(KIND_ACTION, 2, ONE, 1'b0, 0, 0, 0, USE_NONE));
		// negative step ignored while off; floor equals ceiling
		send_item(make_item(KIND_LIMITS, 2, 0, 1'b0, VMAX, VMAX, -1, USE_FLOOR | USE_CEIL));
		send_item(make_item(KIND_ACTION, 2, 0, 1'b0, 0, 0, 0, USE_NONE));
	endtask

	task automatic test_step_saturation();
		send_item(make_item(KIND_LIMITS, 9, 0, 1'b0, VMIN, VMIN, VMAX, USE_STEP));
		send_item(make_item(KIND_SEED, 9, VMAX - 1, 1'b0, 0, 0, 0, USE_NONE));
		send_item(make_item(KIND_ACTION, 9, VMAX, 1'b0, 0, 0, 0, USE_NONE));
		send_item(make_item(KIND_SEED, 9, VMIN + 1, 1'b0, 0, 0, 0, USE_NONE));
		send_item(make_item(KIND_ACTION, 9, VMIN, 1'b0, 0, 0, 0, USE_NONE));
		send_item(make_item(KIND_LIMITS, 9, 0, 1'b0, 0, 0, 0, USE_STEP));
		send_item(make_item(KIND_ACTION, 9, 5 * ONE, 1'b0, 0, 0, 0, USE_NONE));
	endtask

	task automatic test_random_traffic();
		run_random(160);
		wait_for_drain();
		set_reject_bad(1'b0);
		in_gaps_on = 1'b0;
		out_stalls_on = 1'b0;
		run_random(150);
		in_gaps_on = 1'b1;
		out_stalls_on = 1'b1;
		set_reject_bad(1'b1);
		run_random(150);
		set_reject_bad(1'b0);
		run_random(150);
		set_reject_bad(1'b1);
	endtask

	// receiver: random backpressure
	initial begin
		int unsigned hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ready = 1'b0;
				hold--;
			end else begin
				out_ready = 1'b1;
				if (out_stalls_on) begin
					hold = pick_gap();
				end
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected result: filtered %0d outcome %0d axis %0d",
						filtered, outcome, axis_out);
				end
			end else begin
				want = expected_q.pop_front();
				checked_count++;
				outcome_count[outcome]++;
				if (filtered !== want.filtered || outcome !== want.outcome ||
						axis_out !== want.axis) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch: exp filtered %0d outcome %0d axis %0d, got %0d %0d %0d",
							want.filtered, want.outcome, want.axis, filtered, outcome, axis_out);
					end
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("timeout at cycle %0d, %0d results outstanding", cycle_count, expected_q.size());
		$display("joint_clamp_slew_limiter_unit test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		kind = KIND_SEED;
		axis = '0;
		sample = '0;
		sample_bad = 1'b0;
		floor_limit = '0;
		ceiling_limit = '0;
		step_limit = '0;
		floor_on = 1'b0;
		ceiling_on = 1'b0;
		step_on = 1'b0;
		for (int i = 0; i < AXES; i++) begin
			last_pos[i] = '0;
			floor_tbl[i] = '0;
			ceil_tbl[i] = '0;
			step_tbl[i] = '0;
			en_tbl[i] = USE_NONE;
		end
		reject_bad = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_bad_sample_policy();
		test_bounds_and_slew();
		test_step_saturation();
		test_random_traffic();
		wait_for_drain();

		$display("sent %0d seeds, %0d limit loads, %0d actions, %0d unused-kind items",
			kind_count[KIND_SEED], kind_count[KIND_LIMITS], kind_count[KIND_ACTION],
			kind_count[KIND_NONE]);
		$display("checked %0d results: %0d ok, %0d rejected samples, %0d bad limits",
			checked_count, outcome_count[OUTCOME_OK], outcome_count[OUTCOME_BAD],
			outcome_count[OUTCOME_LIMIT]);
		if (fail_count == 0) begin
			$display("joint_clamp_slew_limiter_unit test passed");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("joint_clamp_slew_limiter_unit test failed");
		end
		$finish;
	end

endmodule
